[rtl/core/integer_to_ascii_formatter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII formatter
// Concurrent checks on posedge clk, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define I2A_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("i2a check failed");

// next-cycle implication
`define I2A_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("i2a check failed");

`else

`define I2A_ASSERT_NOW(lbl, ck, rs, ante, cons)
`define I2A_ASSERT_NXT(lbl, ck, rs, ante, cons)

`endif

`endif

[rtl/core/i2a_pkg.sv]
// ----------------------------------------------------------------------------
// i2a_pkg
// Opcodes, character constants and the emit job shared by the formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam logic [2:0] OP_LITERAL = 3'd0;
  localparam logic [2:0] OP_BINARY  = 3'd1;
  localparam logic [2:0] OP_UDEC    = 3'd2;
  localparam logic [2:0] OP_SDEC    = 3'd3;
  localparam logic [2:0] OP_HEX32   = 3'd4;
  localparam logic [2:0] OP_HEX64   = 3'd5;

  localparam int BIN_W      = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int DIG_W      = 64;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_X       = 8'h78;
  localparam logic [7:0] CHAR_MINUS   = 8'h2d;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  // One output run: up to two prefix characters, then digits taken MSB first
  // from dig, each 4 bits wide or 1 bit wide.
  typedef struct packed {
    logic [7:0]       pre0;
    logic [7:0]       pre1;
    logic [1:0]       pre_cnt;
    logic [DIG_W-1:0] dig;
    logic [5:0]       rem;
    logic             wide;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'b0000, d};
    end else begin
      c = CHAR_LOWER_A + {4'b0000, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

[rtl/core/integer_to_ascii_formatter.sv]
// Decimal runs first pass through the bit-serial BCD converter; other runs go
// straight to the emitter, which drops leading zeros before the first digit.
// A new request is taken only once the converter and the emit shift register
// are idle; the shift register takes one digit per cycle while out_stall is low.
// Reset (rst, synchronous) clears the sequencer, converter and output valid.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one opcode/value request into a run of ASCII characters.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_assert.svh"

module integer_to_ascii_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  char_out,
  output logic        last
);

  typedef enum logic {S_IDLE, S_CONV} state_t;

  state_t                     state;
  logic                       neg;
  logic                       in_accept;
  logic                       is_dec;
  logic                       is_imm;
  logic                       emit_idle;
  logic                       emit_start;
  logic                       dab_start;
  logic                       dab_done;
  logic [i2a_pkg::BIN_W-1:0]  dab_bin;
  logic [i2a_pkg::BCD_W-1:0]  dab_bcd;
  i2a_pkg::job_t              imm_job;
  i2a_pkg::job_t              dec_job;
  i2a_pkg::job_t              job;

  assign in_stall  = !((state == S_IDLE) && emit_idle);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    is_dec = 1'b0;
    is_imm = 1'b0;
    imm_job = '0;
    case (opcode) inside
      i2a_pkg::OP_UDEC, i2a_pkg::OP_SDEC: begin
        is_dec = 1'b1;
      end
      i2a_pkg::OP_LITERAL: begin
        is_imm          = 1'b1;
        imm_job.pre0    = value[7:0];
        imm_job.pre_cnt = 2'd1;
      end
      i2a_pkg::OP_BINARY: begin
        is_imm       = 1'b1;
        imm_job.dig  = {value[31:0], 32'h0};
        imm_job.rem  = 6'd32;
      end
      i2a_pkg::OP_HEX32, i2a_pkg::OP_HEX64: begin
        is_imm          = 1'b1;
        imm_job.pre0    = i2a_pkg::CHAR_ZERO;
        imm_job.pre1    = i2a_pkg::CHAR_X;
        imm_job.pre_cnt = 2'd2;
        imm_job.wide    = 1'b1;
        if (opcode == i2a_pkg::OP_HEX64) begin
          imm_job.dig = value;
          imm_job.rem = 6'd16;
        end else begin
          imm_job.dig = {value[31:0], 32'h0};
          imm_job.rem = 6'd8;
        end
      end
      default: begin
        // undefined opcode: take the request, emit nothing
      end
    endcase
  end

  always_comb begin
    dec_job         = '0;
    dec_job.pre0    = i2a_pkg::CHAR_MINUS;
    dec_job.pre_cnt = {1'b0, neg};
    dec_job.dig     = {dab_bcd, {(i2a_pkg::DIG_W - i2a_pkg::BCD_W){1'b0}}};
    dec_job.rem     = 6'(i2a_pkg::BCD_DIGITS);
    dec_job.wide    = 1'b1;
  end

  assign dab_start  = in_accept && is_dec;
  assign dab_bin    = (opcode == i2a_pkg::OP_SDEC && value[31]) ? (32'h0 - value[31:0])
                                                                : value[31:0];
  assign emit_start = (in_accept && is_imm) || dab_done;
  assign job        = dab_done ? dec_job : imm_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (dab_start) begin
            state <= S_CONV;
            neg   <= (opcode == i2a_pkg::OP_SDEC) && value[31];
          end
        end
        S_CONV: begin
          if (dab_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  i2a_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (dab_start),
    .bin   (dab_bin),
    .done  (dab_done),
    .bcd   (dab_bcd)
  );

  i2a_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (emit_start),
    .job       (job),
    .idle      (emit_idle),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out),
    .last      (last)
  );

  `I2A_ASSERT_NOW(a_conv_emit_idle, clk, rst, state == S_CONV, emit_idle)
  `I2A_ASSERT_NOW(a_done_in_conv, clk, rst, dab_done, state == S_CONV)
  `I2A_ASSERT_NOW(a_start_when_idle, clk, rst, emit_start, emit_idle)

endmodule

[rtl/core/i2a_dabble.sv]
// ----------------------------------------------------------------------------
// i2a_dabble
// Bit-serial binary to BCD converter: one input bit per cycle, add-3 fixup.
// ----------------------------------------------------------------------------
module i2a_dabble (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [i2a_pkg::BIN_W-1:0]  bin,
  output logic                       done,
  output logic [i2a_pkg::BCD_W-1:0]  bcd
);

  logic                          busy;
  logic [$clog2(i2a_pkg::BIN_W)-1:0] cnt;
  logic [i2a_pkg::BIN_W-1:0]     sh;
  logic [i2a_pkg::BCD_W-1:0]     bcd_fix;

  always_comb begin
    for (int i = 0; i < i2a_pkg::BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_fix[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_fix[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        sh   <= bin;
        bcd  <= '0;
      end else if (busy) begin
        // shift the next bit into the corrected decimal digits
        bcd <= {bcd_fix[i2a_pkg::BCD_W-2:0], sh[i2a_pkg::BIN_W-1]};
        sh  <= {sh[i2a_pkg::BIN_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/i2a_emit.sv]
// ----------------------------------------------------------------------------
// i2a_emit
// Character emitter: prefix characters, then one digit per cycle from a shift
// register when unstalled, leading zero suppression, registered output stage.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_assert.svh"

module i2a_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  i2a_pkg::job_t       job,
  output logic                idle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          char_out,
  output logic                last
);

  logic [7:0]                pre0;
  logic [7:0]                pre1;
  logic [1:0]                pre_cnt;
  logic [i2a_pkg::DIG_W-1:0] dig;
  logic [5:0]                rem;
  logic                      wide;
  logic                      lead;
  logic [3:0]                cur;
  logic                      slot_free;
  logic [i2a_pkg::DIG_W-1:0] dig_next;

  assign idle      = (pre_cnt == 2'd0) && (rem == 6'd0);
  assign slot_free = !out_valid || !out_stall;
  assign cur       = wide ? dig[i2a_pkg::DIG_W-1 -: 4] : {3'b000, dig[i2a_pkg::DIG_W-1]};
  assign dig_next  = wide ? {dig[i2a_pkg::DIG_W-5:0], 4'b0000}
                          : {dig[i2a_pkg::DIG_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pre_cnt   <= 2'd0;
      rem       <= 6'd0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (start) begin
        pre0    <= job.pre0;
        pre1    <= job.pre1;
        pre_cnt <= job.pre_cnt;
        dig     <= job.dig;
        rem     <= job.rem;
        wide    <= job.wide;
        lead    <= 1'b1;
      end else if (pre_cnt != 2'd0) begin
        if (slot_free) begin
          char_out  <= pre0;
          last      <= (pre_cnt == 2'd1) && (rem == 6'd0);
          out_valid <= 1'b1;
          pre0      <= pre1;
          pre_cnt   <= pre_cnt - 2'd1;
        end
      end else if (rem != 6'd0) begin
        if (lead && (cur == 4'd0) && (rem != 6'd1)) begin
          // drop a leading zero, the final digit always prints
          dig <= dig_next;
          rem <= rem - 6'd1;
        end else if (slot_free) begin
          char_out  <= i2a_pkg::digit_char(cur);
          last      <= (rem == 6'd1);
          out_valid <= 1'b1;
          lead      <= 1'b0;
          dig       <= dig_next;
          rem       <= rem - 6'd1;
        end
      end
    end
  end

  `I2A_ASSERT_NOW(a_more_after_mid, clk, rst, out_valid && !last, !idle)
  `I2A_ASSERT_NOW(a_rem_range, clk, rst, 1'b1, rem <= 6'd32)

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer to ASCII formatter testbench
// Drives opcode/value requests through the valid/stall handshake and checks
// every emitted character and its last flag against a behavioral formatter,
// with random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------

class ascii_run_checker;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } text_char_t;

  text_char_t expected_chars[$];
  logic [7:0] run_text[$];
  int         errors;

  function new();
    errors = 0;
  endfunction

  // Append u in the given base, most significant digit first, padded to min_len.
  function void append_number(logic [31:0] u, logic [31:0] base, int min_len);
    string      digit_set;
    logic [7:0] rev[$];
    digit_set = "0123456789abcdef";
    rev = {};
    do begin
      rev.push_back(digit_set[u % base]);
      u = u / base;
    end while (u != 32'd0);
    while (rev.size() < min_len) rev.push_back(i2a_pkg::CHAR_ZERO);
    while (rev.size() > 0) run_text.push_back(rev.pop_back());
  endfunction

  function void append_hex_prefix();
    run_text.push_back(i2a_pkg::CHAR_ZERO);
    run_text.push_back(i2a_pkg::CHAR_X);
  endfunction

  function void note_request(logic [2:0] op, logic [63:0] val);
    logic [31:0] lo;
    logic [31:0] hi;
    text_char_t  e;
    lo = val[31:0];
    hi = val[63:32];
    run_text = {};
    case (op)
      i2a_pkg::OP_LITERAL: run_text.push_back(val[7:0]);
      i2a_pkg::OP_BINARY:  append_number(lo, 32'd2, 1);
      i2a_pkg::OP_UDEC:    append_number(lo, 32'd10, 1);
      i2a_pkg::OP_SDEC: begin
        if (lo[31]) begin
          run_text.push_back(i2a_pkg::CHAR_MINUS);
          append_number(32'd0 - lo, 32'd10, 1);
        end else begin
          append_number(lo, 32'd10, 1);
        end
      end
      i2a_pkg::OP_HEX32: begin
        append_hex_prefix();
        append_number(lo, 32'd16, 1);
      end
      i2a_pkg::OP_HEX64: begin
        append_hex_prefix();
        if (hi != 32'd0) begin
          append_number(hi, 32'd16, 1);
          append_number(lo, 32'd16, 8);
        end else begin
          append_number(lo, 32'd16, 1);
        end
      end
      default: ;  // undefined opcodes produce nothing
    endcase
    foreach (run_text[i]) begin
      e.ch  = run_text[i];
      e.fin = (i == run_text.size() - 1);
      expected_chars.push_back(e);
    end
  endfunction

  function int pending_count();
    return expected_chars.size();
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 50) $display("MISMATCH %0d: %s", errors, msg);
  endtask

  task check_char(logic [7:0] c, logic l);
    text_char_t e;
    if (expected_chars.size() == 0) begin
      report($sformatf("unexpected char %02h last %0b", c, l));
      return;
    end
    e = expected_chars.pop_front();
    if (c !== e.ch) report($sformatf("char_out %02h, want %02h", c, e.ch));
    if (l !== e.fin) report($sformatf("last %0b on char %02h, want %0b", l, e.ch, e.fin));
  endtask

endclass

module testbench;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int PHASE_ITEMS  = 125;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 64;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [2:0]  opcode    = i2a_pkg::OP_LITERAL;
  logic [63:0] value     = 64'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  char_out;
  logic        last;

  int   send_idle_pct = 13;
  int   recv_idle_pct = 87;
  logic hold_req      = 1'b0;
  logic hold_active   = 1'b0;
  int   idle_cycles;

  logic [2:0] legal_ops [6] = '{i2a_pkg::OP_LITERAL, i2a_pkg::OP_BINARY,
                                i2a_pkg::OP_UDEC,    i2a_pkg::OP_SDEC,
                                i2a_pkg::OP_HEX32,   i2a_pkg::OP_HEX64};

  ascii_run_checker runs = new();

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  integer_to_ascii_formatter u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out),
    .last      (last)
  );

  // Receiver: check accepted characters, then pick next cycle's stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) runs.check_char(char_out, last);
    out_stall <= hold_active || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Long receiver hold-off so the block backs up into its input.
  initial begin : receiver_hold
    wait (hold_req);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("end of test: mismatches");
    $finish;
  end

  task send_request(input logic [2:0] op, input logic [63:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    runs.note_request(op, val);
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = 64'($urandom_range(0, 20));
      1: v = 64'd1 << $urandom_range(0, 63);
      2: v[63:32] = 32'd0;
      3: v[31:0] = 32'd0;
      4: v[63:32] = 32'($urandom_range(0, 15));
      default: ;
    endcase
    return v;
  endfunction

  // Count only requests that produce text; undefined opcodes are mixed in.
  task run_random(input int n);
    int          done;
    int          r;
    logic [2:0]  op;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        op = r[0] ? OP_RSVD7 : OP_RSVD6;
      end else begin
        op = legal_ops[$urandom_range(0, 5)];
      end
      send_request(op, rand_value());
      if (op != OP_RSVD6 && op != OP_RSVD7) done++;
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_request(i2a_pkg::OP_LITERAL, 64'h0);
    send_request(i2a_pkg::OP_LITERAL, 64'hffff_ffff_ffff_ffff);
    send_request(i2a_pkg::OP_LITERAL, 64'h41);
    send_request(i2a_pkg::OP_BINARY,  64'h0);
    send_request(i2a_pkg::OP_BINARY,  64'h1);
    send_request(i2a_pkg::OP_BINARY,  64'hffff_ffff_ffff_ffff);
    send_request(i2a_pkg::OP_BINARY,  64'h8000_0000);
    send_request(i2a_pkg::OP_UDEC,    64'h0);
    send_request(i2a_pkg::OP_UDEC,    64'h0000_0000_ffff_ffff);
    send_request(i2a_pkg::OP_UDEC,    64'hdead_beef_3b9a_ca00);
    send_request(i2a_pkg::OP_SDEC,    64'h0);
    send_request(i2a_pkg::OP_SDEC,    64'hffff_ffff);
    send_request(i2a_pkg::OP_SDEC,    64'h8000_0000);
    send_request(i2a_pkg::OP_SDEC,    64'h7fff_ffff);
    send_request(i2a_pkg::OP_SDEC,    64'h1234_5678_0000_3039);
    send_request(i2a_pkg::OP_HEX32,   64'h0);
    send_request(i2a_pkg::OP_HEX32,   64'hffff_ffff_dead_beef);
    send_request(i2a_pkg::OP_HEX64,   64'h0);
    send_request(i2a_pkg::OP_HEX64,   64'hffff_ffff_ffff_ffff);
    send_request(i2a_pkg::OP_HEX64,   64'h1_0000_0000);
    send_request(i2a_pkg::OP_HEX64,   64'h1_0000_abcd);
    send_request(i2a_pkg::OP_HEX64,   64'h0_1234_5678);
    send_request(OP_RSVD6,            64'h1234);
    send_request(OP_RSVD7,            64'hffff_ffff_ffff_ffff);

    run_random(PHASE_ITEMS);

    send_idle_pct = 87;
    recv_idle_pct = 13;
    run_random(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    run_random(PHASE_ITEMS);

    in_valid <= 1'b0;
    while (runs.pending_count() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (runs.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
